// File: rtl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants for the coil fire timer
// Stream widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 72;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned DIST_W  = 20;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned PROD_W  = DIST_W + SCALE_W;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned IDX_W   = 2;

  localparam logic [SCALE_W-1:0] UM_TO_MM_SCALE = SCALE_W'(1000);

  localparam logic [WIN_W-1:0]  FIRE_WINDOW_RST = WIN_W'(1000);
  localparam logic [WIN_W-1:0]  COOLDOWN_RST    = WIN_W'(10000);
  localparam logic [DIST_W-1:0] DISTANCE_RST    = DIST_W'(20000);

  localparam logic [IDX_W-1:0] REG_FIRE_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_COOLDOWN    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DISTANCE    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_OUT
  } cft_state_t;

endpackage

`default_nettype wire

// File: rtl/coil_fire_timer_with_speed_gate.sv
// ----------------------------------------------------------------------------
// coil_fire_timer_with_speed_gate: coil fire window and hall speed gate
// Each poll sample gives one result: coil level and, when a gate run ends,
// the interval and the speed in mm/s.
// ----------------------------------------------------------------------------
// A sample without a completed measurement passes from acceptance to the
// result register through latch, evaluate and load; a sample that completes a
// measurement also waits in S_DIV for the restoring divider that forms
// distance*1000/interval one quotient bit per cycle over 30 bits. The block
// takes no new sample until the current result is in the output register.
`default_nettype none

module coil_fire_timer_with_speed_gate (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // time_ms[31:0], time_us[63:32], hall_arm[64], hall_start[65], hall_stop[66]
  input  wire logic [cft_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // coil_drive[0], speed_valid[1], interval_us[33:2], speed_mm_s[65:34]
  output logic [cft_pkg::OUT_W-1:0]       m_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [cft_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [cft_pkg::CFG_W-1:0]  cfg_data
);

  import cft_pkg::*;

  cft_state_t state, state_next;

  logic [WIN_W-1:0]  fire_window;
  logic [WIN_W-1:0]  cooldown;
  logic [DIST_W-1:0] distance;

  logic [TIME_W-1:0] arm_time;
  logic [TIME_W-1:0] start_time;

  logic [TIME_W-1:0] smp_ms;
  logic [TIME_W-1:0] smp_us;
  logic              smp_arm;
  logic              smp_start;
  logic              smp_stop;

  logic              res_coil;
  logic              res_valid;
  logic [TIME_W-1:0] res_interval;
  logic [TIME_W-1:0] res_speed;

  logic [TIME_W-1:0] arm_now;
  logic [TIME_W-1:0] elapsed;
  logic              in_window;
  logic              cooling;
  logic              gate_cap;
  logic              gate_stop;
  logic [TIME_W-1:0] gap;
  logic              measure;
  logic [PROD_W-1:0] product;

  logic              accept;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_quot;

  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_window <= FIRE_WINDOW_RST;
      cooldown    <= COOLDOWN_RST;
      distance    <= DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRE_WINDOW: fire_window <= cfg_data[WIN_W-1:0];
        REG_COOLDOWN:    cooldown    <= cfg_data[WIN_W-1:0];
        REG_DISTANCE:    distance    <= cfg_data[DIST_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    arm_now   = (~smp_arm && arm_time == '0) ? smp_ms : arm_time;
    elapsed   = smp_ms - arm_now;
    in_window = elapsed <= TIME_W'(fire_window);
    cooling   = elapsed < TIME_W'(cooldown);
    gate_cap  = smp_arm & ~smp_start & smp_stop & (start_time == '0);
    gate_stop = smp_arm & ~smp_stop & (start_time != '0);
    gap       = smp_us - start_time;
    measure   = gate_stop & (gap > TIME_W'(1));
    product   = PROD_W'(distance) * PROD_W'(UM_TO_MM_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (measure) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_time   <= '0;
      start_time <= '0;
    end else if (state == S_EVAL) begin
      arm_time <= (in_window || cooling) ? arm_now : '0;
      if (gate_cap) begin
        start_time <= smp_us;
      end else if (gate_stop) begin
        start_time <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_ms    <= s_tdata[31:0];
      smp_us    <= s_tdata[63:32];
      smp_arm   <= s_tdata[64];
      smp_start <= s_tdata[65];
      smp_stop  <= s_tdata[66];
    end
    if (state == S_EVAL) begin
      res_coil     <= in_window & ~smp_arm;
      res_valid    <= measure;
      res_interval <= measure ? gap : '0;
      res_speed    <= '0;
    end else if (state == S_DIV && div_done) begin
      res_speed <= TIME_W'(div_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {(OUT_W - 2 - 2 * TIME_W)'(0), res_speed, res_interval, res_valid, res_coil};
    end
  end

  cft_div #(
    .DVD_W (PROD_W),
    .DVS_W (TIME_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (gap),
    .done     (div_done),
    .quotient (div_quot)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EVAL)
    else $error("accepted request not evaluated");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> m_tvalid && state == S_IDLE)
    else $error("result not loaded into output register");

  a_start_measure: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_EVAL && measure)
    else $error("divider started without a measurement");

endmodule

`default_nettype wire

// File: rtl/cft_div.sv
// ----------------------------------------------------------------------------
// cft_div: iterative restoring divider
// One quotient bit per cycle; done pulses once with the quotient held.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_div #(
  parameter int unsigned DVD_W = 30,
  parameter int unsigned DVS_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    trial  = rem_sh - {1'b0, dvs};
    fits   = ~trial[DVS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

// File: dv/tb_coil_fire_timer_with_speed_gate.sv
// ----------------------------------------------------------------------------
// tb_coil_fire_timer_with_speed_gate: self-checking bench for the coil timer
// Opens with a table of directed poll samples on the reset settings, then
// runs several register settings, the extremes among them, each with a
// stream of coherent timestamps and sensor levels mixed with random noise.
// Every sample gives one result. Typed table rows state it; a local model of
// the fire window and gate timer predicts the rest. Each result is checked field
// by field in order. Sender bursts, receiver stall patterns and one long
// receiver hold-off are used to vary the handshake timing.
// ----------------------------------------------------------------------------
module tb_coil_fire_timer_with_speed_gate;
  timeunit 1ns;
  timeprecision 1ps;

  import cft_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int N_PHASES    = 13;
  localparam int PHASE_ITEMS = 110;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic        hall_stop;
    logic        hall_start;
    logic        hall_arm;
    logic [31:0] time_us;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [31:0] speed_mm_s;
    logic [31:0] interval_us;
    logic        speed_valid;
    logic        coil_drive;
  } shot_t;

  typedef struct {
    logic [31:0] ms;
    logic [31:0] us;
    bit          arm;
    bit          st;
    bit          sp;
    bit          typed;
    bit          coil;
    bit          vld;
    logic [31:0] intv;
    logic [31:0] spd;
  } probe_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  coil_fire_timer_with_speed_gate dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [15:0] fire_win;
  logic [15:0] cool_ms;
  logic [19:0] gap_dist;
  logic [31:0] armed_at;
  logic [31:0] gate_t0;

  shot_t  shots_due[$];
  int     faults;
  int     shot_no;
  int     burst_left;
  bit     hold_req;
  probe_t probes [24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void log_fault(input string what);
    faults++;
    if (faults <= 10) $display("%s", what);
  endfunction

  function automatic void reset_model();
    fire_win = FIRE_WINDOW_RST;
    cool_ms  = COOLDOWN_RST;
    gap_dist = DISTANCE_RST;
    armed_at = '0;
    gate_t0  = '0;
  endfunction

  function automatic shot_t predict_shot(input sample_t s);
    shot_t       r;
    logic [31:0] lap;
    logic [31:0] span;
    r = '0;
    if (!s.hall_arm) begin
      if (armed_at == 0) armed_at = s.time_ms;
    end else begin
      if (!s.hall_start && s.hall_stop && gate_t0 == 0) gate_t0 = s.time_us;
      if (!s.hall_stop && gate_t0 != 0) begin
        span = s.time_us - gate_t0;
        if (span > 1) begin
          r.speed_valid = 1'b1;
          r.interval_us = span;
          r.speed_mm_s  = 32'((64'(gap_dist) * 64'd1000) / 64'(span));
        end
        gate_t0 = '0;
      end
    end
    lap = s.time_ms - armed_at;
    if (lap <= 32'(fire_win)) r.coil_drive = ~s.hall_arm;
    else if (lap >= 32'(cool_ms)) armed_at = '0;
    return r;
  endfunction

  task automatic offer(input sample_t smp, input bit typed, input shot_t want);
    int    gap;
    shot_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata  <= {5'b0, smp};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_shot(smp);
    shots_due.push_back(typed ? want : r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (shots_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] fw, input logic [15:0] cd,
                          input logic [19:0] gate_um, input bit poke);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIRE_WINDOW;
    cfg_data  <= {4'($urandom), fw};
    @(posedge clk);
    cfg_index <= REG_COOLDOWN;
    cfg_data  <= {4'($urandom), cd};
    @(posedge clk);
    cfg_index <= REG_DISTANCE;
    cfg_data  <= gate_um;
    @(posedge clk);
    if (poke) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= 20'($urandom);
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    fire_win = fw;
    cool_ms  = cd;
    gap_dist = gate_um;
  endtask

  always @(posedge clk) begin
    shot_t want;
    shot_t got;
    if (!rst && m_tvalid && m_tready) begin
      shot_no++;
      got = m_tdata[$bits(shot_t)-1:0];
      if (shots_due.size() == 0) begin
        log_fault($sformatf("result %0d arrived with nothing expected", shot_no));
      end else begin
        want = shots_due.pop_front();
        if (got.coil_drive !== want.coil_drive || got.speed_valid !== want.speed_valid ||
            got.interval_us !== want.interval_us || got.speed_mm_s !== want.speed_mm_s)
          log_fault($sformatf({"result %0d: expected coil=%0d valid=%0d interval=%0d ",
                               "speed=%0d, got coil=%0d valid=%0d interval=%0d speed=%0d"},
                              shot_no, want.coil_drive, want.speed_valid, want.interval_us,
                              want.speed_mm_s, got.coil_drive, got.speed_valid,
                              got.interval_us, got.speed_mm_s));
      end
    end
  end

  initial begin : receiver
    int         run;
    logic [7:0] pat;
    run = 0;
    pat = '1;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (run == 0) begin
          run = 8;
          case ($urandom_range(0, 3))
            0:       pat = '1;
            1:       pat = 8'($urandom);
            2:       pat = 8'($urandom | $urandom);
            default: pat = 8'($urandom & $urandom);
          endcase
        end
        m_tready <= pat[run-1];
        run--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    sample_t     smp;
    shot_t       want;
    logic [31:0] clock_ms;
    logic [31:0] clock_us;
    logic [15:0] fw;
    logic [15:0] cd;
    logic [19:0] gate_um;
    int          step_ms;
    bit          poke;

    faults     = 0;
    shot_no    = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_model();

    probes = '{
      '{32'd0,     32'd0,          1, 1, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd0,     32'd5,          0, 1, 1, 1, 1, 0, 32'd0,          32'd0},
      '{32'd2000,  32'd10,         1, 1, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd2000,  32'd0,          1, 0, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd2000,  32'd100,        1, 1, 0, 1, 0, 0, 32'd0,          32'd0},
      '{32'd3000,  32'd100,        1, 0, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd3000,  32'd101,        1, 1, 0, 1, 0, 0, 32'd0,          32'd0},
      '{32'd3000,  32'd200,        1, 0, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd3000,  32'd202,        1, 1, 0, 1, 0, 1, 32'd2,          32'd10000000},
      '{32'd3000,  32'd300,        1, 0, 0, 1, 0, 0, 32'd0,          32'd0},
      '{32'd3000,  32'hFFFF_FFF0,  1, 0, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd3000,  32'd16,         1, 1, 0, 1, 0, 1, 32'd32,         32'd625000},
      '{32'hFFFF_FFFF, 32'd20,     0, 1, 1, 1, 1, 0, 32'd0,          32'd0},
      '{32'd999,   32'd30,         0, 1, 1, 1, 1, 0, 32'd0,          32'd0},
      '{32'd1000,  32'd40,         0, 1, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd5000,  32'd1000,       1, 0, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd5000,  32'd3000,       0, 1, 0, 1, 0, 0, 32'd0,          32'd0},
      '{32'd9998,  32'd4000,       1, 1, 0, 1, 0, 1, 32'd3000,       32'd6666},
      '{32'd9999,  32'd4100,       1, 1, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd10000, 32'd4200,       0, 1, 1, 1, 1, 0, 32'd0,          32'd0},
      '{32'd10000, 32'd1,          1, 0, 1, 1, 0, 0, 32'd0,          32'd0},
      '{32'd10000, 32'd0,          1, 1, 0, 1, 0, 1, 32'hFFFF_FFFF,  32'd0},
      '{32'd11000, 32'd50,         0, 0, 0, 0, 0, 0, 32'd0,          32'd0},
      '{32'd11001, 32'd60,         1, 0, 0, 0, 0, 0, 32'd0,          32'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      smp.time_ms    = probes[i].ms;
      smp.time_us    = probes[i].us;
      smp.hall_arm   = probes[i].arm;
      smp.hall_start = probes[i].st;
      smp.hall_stop  = probes[i].sp;
      want.coil_drive  = probes[i].coil;
      want.speed_valid = probes[i].vld;
      want.interval_us = probes[i].intv;
      want.speed_mm_s  = probes[i].spd;
      offer(smp, probes[i].typed, want);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      poke = 1'b0;
      case (ph)
        0: begin fw = 16'd0;     cd = 16'd0;     gate_um = 20'd1;       step_ms = 2;
                 poke = 1'b1; end
        1: begin fw = 16'hFFFF;  cd = 16'hFFFF;  gate_um = 20'hFFFFF;   step_ms = 3000; end
        2: begin fw = 16'd20;    cd = 16'd100;   gate_um = 20'd0;       step_ms = 6; end
        3: begin fw = 16'd50;    cd = 16'd10;    gate_um = DISTANCE_RST; step_ms = 8; end
        default: begin
          fw      = 16'($urandom_range(0, 60));
          cd      = 16'($urandom_range(0, 300));
          gate_um = 20'($urandom);
          step_ms = $urandom_range(1, 20);
        end
      endcase
      set_regs(fw, cd, gate_um, poke);

      clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400)
                                              : $urandom;
      clock_us = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                              : $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == 15) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 15) begin
          smp.time_ms = $urandom;
          smp.time_us = $urandom;
          {smp.hall_arm, smp.hall_start, smp.hall_stop} = 3'($urandom);
        end else begin
          clock_ms += $urandom_range(0, step_ms);
          clock_us += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 2500);
          smp.time_ms    = clock_ms;
          smp.time_us    = clock_us;
          smp.hall_arm   = ($urandom_range(0, 3) != 0);
          smp.hall_start = ($urandom_range(0, 9) >= 3);
          smp.hall_stop  = ($urandom_range(0, 3) != 0);
        end
        offer(smp, 1'b0, '0);
      end
      drain();
    end

    if (shots_due.size() != 0)
      log_fault($sformatf("%0d results never arrived", shots_due.size()));
    if (faults == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
